// ===== rtl/rsb_pkg.sv =====
// ----------------------------------------------------------------------------
// rsb_pkg: shared types and constants for the retry slot buffer
// Holds the action codes, result kinds, controller states, default slot count and retry budget.
// ----------------------------------------------------------------------------
package rsb_pkg;

  localparam int unsigned DefSlots  = 256;
  localparam logic [7:0]  DefBudget = 8'd128;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_REPLY = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    K_ACCEPT = 3'd0,
    K_REFUSE = 3'd1,
    K_OFFER  = 3'd2,
    K_END    = 3'd3,
    K_IGNORE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_SCAN,
    ST_WALK_SCAN,
    ST_REPLY_RD,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/rsb_ram.sv =====
// ----------------------------------------------------------------------------
// rsb_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module rsb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/retry_slot_buffer.sv =====
// ----------------------------------------------------------------------------
// retry_slot_buffer: ring of message slots with a per-entry retry budget
// Push finds a free slot, tick starts a delivery walk, reply resolves offers.
// ----------------------------------------------------------------------------
//   channel | signals                                        | dir
//   in      | in_valid_i/in_ready_o, action..delivered_ok    | in
//   out     | out_valid_o/out_ready_i, kind..occupied        | out
//   cfg     | cfg_valid_i/cfg_ready_o, cfg_data_i            | in
//
// One item at a time. A push or walk step probes one slot per cycle through
// the slot memories, whose read data is registered. After reset a clearing
// pass frees every slot; no item is taken meanwhile. The result waits in an
// output register; the next item is taken once that register is free.
module retry_slot_buffer #(
  parameter int unsigned SLOTS = rsb_pkg::DefSlots,
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned CW = $clog2(SLOTS + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] client_id_i,
  input  logic [31:0] frame_tag_i,
  input  logic [15:0] frame_len_i,
  input  logic        delivered_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  slot_o,
  output logic [15:0] out_client_o,
  output logic [31:0] out_tag_o,
  output logic [15:0] out_len_o,
  output logic        dropped_o,
  output logic [8:0]  occupied_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam logic [AW-1:0] LastSlot = AW'(SLOTS - 1);

  rsb_pkg::state_e state_q, state_d;
  logic            clr_q, clr_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic            rd_q, rd_d;          // memory read launched last cycle
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   push_q, push_d;
  logic [AW-1:0]   pop_q, pop_d;
  logic [AW-1:0]   wpos_q, wpos_d;
  logic [CW-1:0]   wleft_q, wleft_d;
  logic            walking_q, walking_d;
  logic [7:0]      budget_q;
  logic            ok_q, ok_d, drop_q, drop_d;
  logic [15:0]     pclient_q, pclient_d, plen_q, plen_d;
  logic [31:0]     ptag_q, ptag_d;

  logic            ov_q, ov_d;
  logic [2:0]      kind_q, kind_d;
  logic [7:0]      slot_q, slot_d;
  logic [15:0]     oc_q, oc_d, ol_q, ol_d;
  logic [31:0]     ot_q, ot_d;
  logic            odrop_q, odrop_d;

  // memories
  logic            cl_we, dt_we, rt_we;
  logic [AW-1:0]   mem_addr;
  logic [15:0]     cl_wdata, cl_rdata;
  logic [47:0]     dt_rdata;
  logic [8:0]      rt_wdata, rt_rdata;

  rsb_ram #(.Width(16), .Depth(SLOTS)) u_client (
    .clk_i, .we_i(cl_we), .addr_i(mem_addr), .wdata_i(cl_wdata), .rdata_o(cl_rdata)
  );
  rsb_ram #(.Width(48), .Depth(SLOTS)) u_data (
    .clk_i, .we_i(dt_we), .addr_i(mem_addr), .wdata_i({ptag_q, plen_q}),
    .rdata_o(dt_rdata)
  );
  rsb_ram #(.Width(9), .Depth(SLOTS)) u_retry (
    .clk_i, .we_i(rt_we), .addr_i(mem_addr), .wdata_i(rt_wdata), .rdata_o(rt_rdata)
  );

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] a);
    return (a == LastSlot) ? '0 : a + 1'b1;
  endfunction

  assign in_ready_o  = (state_q == rsb_pkg::ST_IDLE) && !clr_q && !ov_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    addr_d    = addr_q;
    rd_d      = 1'b0;
    count_d   = count_q;
    push_d    = push_q;
    pop_d     = pop_q;
    wpos_d    = wpos_q;
    wleft_d   = wleft_q;
    walking_d = walking_q;
    ok_d      = ok_q;
    drop_d    = drop_q;
    pclient_d = pclient_q;
    ptag_d    = ptag_q;
    plen_d    = plen_q;
    ov_d      = ov_q && !out_ready_i;
    kind_d    = kind_q;
    slot_d    = slot_q;
    oc_d      = oc_q;
    ot_d      = ot_q;
    ol_d      = ol_q;
    odrop_d   = odrop_q;
    cl_we     = 1'b0;
    dt_we     = 1'b0;
    rt_we     = 1'b0;
    cl_wdata  = '0;
    rt_wdata  = {1'b0, budget_q};
    mem_addr  = addr_q;

    case (state_q)
      rsb_pkg::ST_IDLE: begin
        if (clr_q) begin
          cl_we  = 1'b1;
          addr_d = nxt(addr_q);
          if (addr_q == LastSlot) begin
            clr_d = 1'b0;
          end
        end else if (in_valid_i && in_ready_o) begin
          drop_d  = 1'b0;
          kind_d  = rsb_pkg::K_IGNORE;
          slot_d  = '0;
          oc_d    = '0;
          ot_d    = '0;
          ol_d    = '0;
          state_d = rsb_pkg::ST_OUT;
          case (action_i)
            rsb_pkg::ACT_PUSH: begin
              if (client_id_i != '0) begin
                if (count_q == CW'(SLOTS)) begin
                  kind_d = rsb_pkg::K_REFUSE;
                end else begin
                  pclient_d = client_id_i;
                  ptag_d    = frame_tag_i;
                  plen_d    = frame_len_i;
                  addr_d    = push_q;
                  mem_addr  = push_q;
                  rd_d      = 1'b1;
                  state_d   = rsb_pkg::ST_PUSH_SCAN;
                end
              end
            end
            rsb_pkg::ACT_TICK: begin
              if (!walking_q) begin
                if (count_q == '0) begin
                  kind_d = rsb_pkg::K_END;
                end else begin
                  pop_d    = nxt(pop_q);
                  addr_d   = pop_q;
                  mem_addr = pop_q;
                  rd_d     = 1'b1;
                  wleft_d  = CW'(SLOTS);
                  state_d  = rsb_pkg::ST_WALK_SCAN;
                end
              end
            end
            rsb_pkg::ACT_REPLY: begin
              if (walking_q) begin
                ok_d     = delivered_ok_i;
                addr_d   = wpos_q;
                mem_addr = wpos_q;
                state_d  = rsb_pkg::ST_REPLY_RD;
              end
            end
            default: ;
          endcase
        end
      end

      rsb_pkg::ST_PUSH_SCAN: begin
        // count below SLOTS guarantees a free slot within one lap
        if (rd_q && cl_rdata == '0) begin
          cl_we    = 1'b1;
          cl_wdata = pclient_q;
          dt_we    = 1'b1;
          rt_we    = 1'b1;
          push_d   = nxt(addr_q);
          count_d  = count_q + 1'b1;
          kind_d   = rsb_pkg::K_ACCEPT;
          slot_d   = 8'(addr_q);
          state_d  = rsb_pkg::ST_OUT;
        end else if (rd_q) begin
          addr_d   = nxt(addr_q);
          mem_addr = nxt(addr_q);
          rd_d     = 1'b1;
        end else begin
          rd_d = 1'b1;
        end
      end

      rsb_pkg::ST_WALK_SCAN: begin
        if (wleft_q == '0) begin
          walking_d = 1'b0;
          kind_d    = rsb_pkg::K_END;
          slot_d    = '0;
          state_d   = rsb_pkg::ST_OUT;
        end else if (rd_q) begin
          wleft_d = wleft_q - 1'b1;
          if (cl_rdata != '0) begin
            walking_d = 1'b1;
            wpos_d    = addr_q;
            kind_d    = rsb_pkg::K_OFFER;
            slot_d    = 8'(addr_q);
            oc_d      = cl_rdata;
            ot_d      = dt_rdata[47:16];
            ol_d      = dt_rdata[15:0];
            state_d   = rsb_pkg::ST_OUT;
          end else begin
            addr_d   = nxt(addr_q);
            mem_addr = nxt(addr_q);
            rd_d     = 1'b1;
          end
        end else begin
          rd_d = 1'b1;
        end
      end

      rsb_pkg::ST_REPLY_RD: begin
        if (!rd_q) begin
          rd_d = 1'b1;
        end else if (ok_q || rt_rdata == '0) begin
          drop_d  = !ok_q;
          cl_we   = 1'b1;
          if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end
          addr_d  = nxt(addr_q);
          state_d = rsb_pkg::ST_WALK_SCAN;
        end else begin
          rt_we     = 1'b1;
          rt_wdata  = rt_rdata - 1'b1;
          pop_d     = nxt(addr_q);
          walking_d = 1'b0;
          kind_d    = rsb_pkg::K_END;
          slot_d    = 8'(addr_q);
          state_d   = rsb_pkg::ST_OUT;
        end
      end

      rsb_pkg::ST_OUT: begin
        ov_d    = 1'b1;
        odrop_d = drop_q;
        state_d = rsb_pkg::ST_IDLE;
      end

      default: state_d = rsb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rsb_pkg::ST_IDLE;
      clr_q     <= 1'b1;
      addr_q    <= '0;
      rd_q      <= 1'b0;
      count_q   <= '0;
      push_q    <= '0;
      pop_q     <= '0;
      wpos_q    <= '0;
      wleft_q   <= '0;
      walking_q <= 1'b0;
      budget_q  <= rsb_pkg::DefBudget;
      ov_q      <= 1'b0;
      drop_q    <= 1'b0;
      odrop_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      addr_q    <= addr_d;
      rd_q      <= rd_d;
      count_q   <= count_d;
      push_q    <= push_d;
      pop_q     <= pop_d;
      wpos_q    <= wpos_d;
      wleft_q   <= wleft_d;
      walking_q <= walking_d;
      ov_q      <= ov_d;
      drop_q    <= drop_d;
      odrop_q   <= odrop_d;
      if (cfg_valid_i) begin
        budget_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q      <= ok_d;
    pclient_q <= pclient_d;
    ptag_q    <= ptag_d;
    plen_q    <= plen_d;
    kind_q    <= kind_d;
    slot_q    <= slot_d;
    oc_q      <= oc_d;
    ot_q      <= ot_d;
    ol_q      <= ol_d;
  end

  assign out_valid_o  = ov_q;
  assign kind_o       = kind_q;
  assign slot_o       = slot_q;
  assign out_client_o = oc_q;
  assign out_tag_o    = ot_q;
  assign out_len_o    = ol_q;
  assign dropped_o    = odrop_q;
  assign occupied_o   = 9'(count_q);

endmodule

// ===== tb/rsb_checker.sv =====
// ----------------------------------------------------------------------------
// rsb_checker: result predictor and scoreboard for retry_slot_buffer
// Watches the input, output and config channels, keeps its own copy of the
// slot ring, and compares each result against the oldest prediction.
// ----------------------------------------------------------------------------
module rsb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] client_id_i,
  input  logic [31:0] frame_tag_i,
  input  logic [15:0] frame_len_i,
  input  logic        delivered_ok_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  slot_i,
  input  logic [15:0] out_client_i,
  input  logic [31:0] out_tag_i,
  input  logic [15:0] out_len_i,
  input  logic        dropped_i,
  input  logic [8:0]  occupied_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output logic        walk_open_o
);

  typedef struct packed {
    rsb_pkg::kind_e kind;
    logic [7:0]     slot;
    logic [15:0]    client;
    logic [31:0]    tag;
    logic [15:0]    len;
    logic           dropped;
    logic [8:0]     occupied;
  } slot_result_t;

  logic [15:0] ring_client [256];
  logic [31:0] ring_tag    [256];
  logic [15:0] ring_len    [256];
  logic [8:0]  ring_budget [256];
  int          n_entries;
  logic [7:0]  push_ptr, pop_ptr, walk_ptr;
  int          walk_budget;
  logic        in_walk;
  logic [7:0]  budget_reg;

  slot_result_t pending_results[$];

  initial begin
    errors_o    = 0;
    pending_o   = 0;
    walk_open_o = 1'b0;
  end

  // next occupied slot on the walk, or walk end
  function automatic void walk_next(ref slot_result_t r);
    bit found;
    found = 1'b0;
    while (walk_budget > 0 && !found) begin
      walk_budget--;
      if (ring_client[walk_ptr] != 16'd0) found = 1'b1;
      else walk_ptr = walk_ptr + 8'd1;
    end
    if (found) begin
      in_walk  = 1'b1;
      r.kind   = rsb_pkg::K_OFFER;
      r.slot   = walk_ptr;
      r.client = ring_client[walk_ptr];
      r.tag    = ring_tag[walk_ptr];
      r.len    = ring_len[walk_ptr];
    end else begin
      in_walk = 1'b0;
      r.kind  = rsb_pkg::K_END;
    end
  endfunction

  function automatic slot_result_t predict_result(logic [1:0] act, logic [15:0] cid,
                                                  logic [31:0] tg, logic [15:0] ln,
                                                  logic ok);
    slot_result_t r;
    logic [7:0]   p;
    r      = '0;
    r.kind = rsb_pkg::K_IGNORE;
    case (act)
      rsb_pkg::ACT_PUSH: begin
        if (cid == 16'd0) begin
          r.kind = rsb_pkg::K_IGNORE;
        end else begin
          r.kind = rsb_pkg::K_REFUSE;
          p = push_ptr;
          if (n_entries < 256) begin
            for (int i = 0; i < 256; i++) begin
              if (ring_client[p] == 16'd0) begin
                ring_client[p] = cid;
                ring_tag[p]    = tg;
                ring_len[p]    = ln;
                ring_budget[p] = {1'b0, budget_reg};
                push_ptr       = p + 8'd1;
                n_entries++;
                r.kind = rsb_pkg::K_ACCEPT;
                r.slot = p;
                break;
              end
              p = p + 8'd1;
            end
          end
        end
      end
      rsb_pkg::ACT_TICK: begin
        if (in_walk) r.kind = rsb_pkg::K_IGNORE;
        else if (n_entries == 0) r.kind = rsb_pkg::K_END;
        else begin
          walk_ptr    = pop_ptr;
          pop_ptr     = walk_ptr + 8'd1;
          walk_budget = 256;
          walk_next(r);
        end
      end
      rsb_pkg::ACT_REPLY: begin
        if (!in_walk) begin
          r.kind = rsb_pkg::K_IGNORE;
        end else begin
          p = walk_ptr;
          if (ok || ring_budget[p] == 9'd0) begin
            r.dropped = !ok;
            ring_client[p] = 16'd0;
            if (n_entries > 0) n_entries--;
            walk_ptr = p + 8'd1;
            walk_next(r);
          end else begin
            ring_budget[p] = ring_budget[p] - 9'd1;
            pop_ptr = p + 8'd1;
            in_walk = 1'b0;
            r.kind  = rsb_pkg::K_END;
            r.slot  = p;
          end
        end
      end
      default: r.kind = rsb_pkg::K_IGNORE;
    endcase
    r.occupied = n_entries[8:0];
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t want;
    if (!rst_ni) begin
      foreach (ring_client[i]) ring_client[i] = 16'd0;
      n_entries   = 0;
      push_ptr    = 8'd0;
      pop_ptr     = 8'd0;
      walk_ptr    = 8'd0;
      walk_budget = 0;
      in_walk     = 1'b0;
      budget_reg  = rsb_pkg::DefBudget;
      pending_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d", $time, kind_i);
          errors_o++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, kind_i);
          check_field("slot", want.slot, slot_i);
          check_field("out_client", want.client, out_client_i);
          check_field("out_tag", want.tag, out_tag_i);
          check_field("out_len", want.len, out_len_i);
          check_field("dropped", want.dropped, dropped_i);
          check_field("occupied", want.occupied, occupied_i);
        end
      end
      if (in_valid_i && in_ready_i)
        pending_results.push_back(predict_result(action_i, client_id_i, frame_tag_i,
                                                 frame_len_i, delivered_ok_i));
      if (cfg_valid_i && cfg_ready_i) budget_reg = cfg_data_i;
    end
    pending_o   <= pending_results.size();
    walk_open_o <= in_walk;
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for retry_slot_buffer
// Directed corner items, then random push/tick/reply traffic over several
// retry budgets, with random idling on both channels; rsb_checker scores it.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         StallLimit = 5000;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic [1:0]  action_i       = rsb_pkg::ACT_PUSH;
  logic [15:0] client_id_i    = '0;
  logic [31:0] frame_tag_i    = '0;
  logic [15:0] frame_len_i    = '0;
  logic        delivered_ok_i = 1'b0;
  logic        out_ready_i    = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic [7:0]  cfg_data_i     = '0;
  logic        in_ready_o, out_valid_o, dropped_o, cfg_ready_o;
  logic [2:0]  kind_o;
  logic [7:0]  slot_o;
  logic [15:0] out_client_o, out_len_o;
  logic [31:0] out_tag_o;
  logic [8:0]  occupied_o;
  int          errors, pending;
  logic        walk_open;
  bit          idling = 1'b1;
  int          quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  retry_slot_buffer u_dut (.*);

  rsb_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i, .client_id_i,
    .frame_tag_i, .frame_len_i, .delivered_ok_i, .out_valid_i(out_valid_o), .out_ready_i,
    .kind_i(kind_o), .slot_i(slot_o), .out_client_i(out_client_o), .out_tag_i(out_tag_o),
    .out_len_i(out_len_o), .dropped_i(dropped_o), .occupied_i(occupied_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_data_i, .errors_o(errors), .pending_o(pending),
    .walk_open_o(walk_open)
  );

  always @(posedge clk_i) begin
    out_ready_i <= !(idling && $urandom_range(99) < 27);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] act, logic [15:0] cid, logic [31:0] tg,
                           logic [15:0] ln, logic ok);
    in_valid_i     <= 1'b1;
    action_i       <= act;
    client_id_i    <= cid;
    frame_tag_i    <= tg;
    frame_len_i    <= ln;
    delivered_ok_i <= ok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // gap after the item, so valid is never dropped and raised in one step
    if (idling && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 27);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_budget(logic [7:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_random();
    send_item(rsb_pkg::ACT_PUSH, 16'($urandom_range(65535, 1)), $urandom,
              16'($urandom), 1'b0);
  endtask

  // mostly walk replies while a walk is open, otherwise pushes, ticks and some noise
  task automatic random_traffic(int n_items, int calm_from, int calm_to);
    int pick;
    for (int i = 0; i < n_items; i++) begin
      idling = !(i >= calm_from && i < calm_to);
      pick   = $urandom_range(99);
      if (walk_open && pick < 85)
        send_item(rsb_pkg::ACT_REPLY, 16'($urandom), $urandom, 16'($urandom),
                  1'($urandom_range(99) < 55));
      else if (pick < 50) push_random();
      else if (pick < 88)
        send_item(rsb_pkg::ACT_TICK, 16'($urandom), $urandom, 16'($urandom), 1'b0);
      else if (pick < 93)
        send_item(rsb_pkg::ACT_PUSH, 16'd0, $urandom, 16'($urandom), 1'b0);
      else if (pick < 97) send_item(ACT_UNUSED, 16'($urandom), $urandom, 16'($urandom), 1'b1);
      else send_item(rsb_pkg::ACT_REPLY, 16'($urandom), $urandom, 16'($urandom),
                     1'($urandom));
    end
    idling = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty ring, stray replies, unknown action, zero client
    send_item(rsb_pkg::ACT_TICK, 16'd0, 32'd0, 16'd0, 1'b0);
    send_item(rsb_pkg::ACT_REPLY, 16'd0, 32'd0, 16'd0, 1'b1);
    send_item(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_item(rsb_pkg::ACT_PUSH, 16'd0, 32'h1234_5678, 16'd9, 1'b0);
    send_item(rsb_pkg::ACT_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_item(rsb_pkg::ACT_PUSH, 16'd1, 32'd0, 16'd0, 1'b0);
    // push while walking, failing reply stops walk, tick while walking
    send_item(rsb_pkg::ACT_TICK, 16'd0, 32'd0, 16'd0, 1'b0);
    send_item(rsb_pkg::ACT_PUSH, 16'd2, 32'hA5A5_5A5A, 16'd77, 1'b0);
    send_item(rsb_pkg::ACT_REPLY, 16'd0, 32'd0, 16'd0, 1'b1);
    send_item(rsb_pkg::ACT_REPLY, 16'd0, 32'd0, 16'd0, 1'b0);
    send_item(rsb_pkg::ACT_TICK, 16'd0, 32'd0, 16'd0, 1'b0);
    send_item(rsb_pkg::ACT_TICK, 16'd0, 32'd0, 16'd0, 1'b0);
    send_item(rsb_pkg::ACT_REPLY, 16'd0, 32'd0, 16'd0, 1'b1);
    send_item(rsb_pkg::ACT_REPLY, 16'd0, 32'd0, 16'd0, 1'b1);

    // zero budget: failures drop, a drop followed by an offer
    write_budget(8'd0);
    send_item(rsb_pkg::ACT_PUSH, 16'd3, 32'd3, 16'd3, 1'b0);
    send_item(rsb_pkg::ACT_PUSH, 16'd4, 32'd4, 16'd4, 1'b0);
    send_item(rsb_pkg::ACT_TICK, 16'd0, 32'd0, 16'd0, 1'b0);
    send_item(rsb_pkg::ACT_REPLY, 16'd0, 32'd0, 16'd0, 1'b0);
    send_item(rsb_pkg::ACT_REPLY, 16'd0, 32'd0, 16'd0, 1'b0);

    write_budget(8'd255);
    random_traffic(300, 100, 200);

    // fill the ring until pushes are refused
    write_budget(8'd3);
    for (int i = 0; i < 270; i++) push_random();
    random_traffic(230, 0, 0);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
